// ===== sv/mrpt_pkg.sv =====
`timescale 1ns / 1ps
// shared types, codes and default sizes for the msi-x relay pending table
// no dependencies

package mrpt_pkg;

  localparam int DEF_MAX_VECTORS        = 32;
  localparam int DEF_TABLE_BASE         = 4096;
  localparam int DEF_OUTSTANDING_OFFSET = 4;
  localparam int DEF_PENDING_OFFSET     = 8;

  localparam int ENTRY_BYTES = 16;
  localparam int ENTRY_SHIFT = $clog2(ENTRY_BYTES);

  localparam int OP_W       = 3;
  localparam int ADDR_W     = 16;
  localparam int DATA_W     = 32;
  localparam int MSI_ADDR_W = 64;
  localparam int VEC_W      = 5;
  localparam int CNT_W      = 6;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int MSG_W      = 16;

  localparam logic [OP_W-1:0] OP_CSR_RD = 3'd0;
  localparam logic [OP_W-1:0] OP_CSR_WR = 3'd1;
  localparam logic [OP_W-1:0] OP_MSI_WR = 3'd2;
  localparam logic [OP_W-1:0] OP_MSI_RD = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK   = 3'd4;

  localparam logic [1:0] FLD_ADDR_LO = 2'd0;
  localparam logic [1:0] FLD_ADDR_HI = 2'd1;
  localparam logic [1:0] FLD_DATA    = 2'd2;
  localparam logic [1:0] FLD_MASK    = 2'd3;

  localparam logic [KIND_W-1:0] KIND_ACCESS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EMIT   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FMASK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd2;

  localparam logic [CNT_W-1:0] COUNT_RESET = 6'd32;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_RECV,
    ACT_PBA_READ,
    ACT_TBL_READ,
    ACT_TBL_WRITE,
    ACT_EMIT,
    ACT_IDLE_TICK
  } act_t;

  typedef struct packed {
    act_t             act;
    logic             status;
    logic [VEC_W-1:0] vec;
    logic [1:0]       field;
  } look_t;

  typedef struct packed {
    logic              en;
    logic [1:0]        field;
    logic [VEC_W-1:0]  vec;
    logic [DATA_W-1:0] wdata;
  } tbl_wr_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_READ,
    S_FIN
  } state_t;

endpackage

// ===== sv/mrpt_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces for requests and responses
// depends on mrpt_pkg

interface mrpt_in_if import mrpt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;
  logic              sink_ok;

  modport source (output valid, op, address, write_data, sink_ok, input ready);
  modport sink (input valid, op, address, write_data, sink_ok, output ready);
endinterface

interface mrpt_out_if import mrpt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     resp_kind;
  logic                  status;
  logic [DATA_W-1:0]     read_data;
  logic [MSI_ADDR_W-1:0] msi_address;
  logic [DATA_W-1:0]     msi_data;
  logic [VEC_W-1:0]      msi_vector;

  modport source (output valid, resp_kind, status, read_data, msi_address, msi_data,
                  msi_vector, input ready);
  modport sink (input valid, resp_kind, status, read_data, msi_address, msi_data,
                msi_vector, output ready);
endinterface

// ===== sv/mrpt_table.sv =====
`timescale 1ns / 1ps
// vector table storage: address and data memories with valid bits, mask flops
// depends on mrpt_pkg

module mrpt_table import mrpt_pkg::*; #(
  parameter int MAX_VECTORS = DEF_MAX_VECTORS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tbl_wr_t                wr,
  input  logic                   rd_en,
  input  logic [VEC_W-1:0]       rd_vec,
  output logic [DATA_W-1:0]      rd_addr_lo,
  output logic [DATA_W-1:0]      rd_addr_hi,
  output logic [DATA_W-1:0]      rd_data,
  output logic [MAX_VECTORS-1:0] mask,
  output logic [MAX_VECTORS-1:0] nonzero
);

  localparam int VW = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;

  logic [DATA_W-1:0] mem_lo   [MAX_VECTORS];
  logic [DATA_W-1:0] mem_hi   [MAX_VECTORS];
  logic [DATA_W-1:0] mem_data [MAX_VECTORS];

  logic [MAX_VECTORS-1:0] vld_lo, vld_hi, vld_data, lo_nz, hi_nz;
  logic [DATA_W-1:0]      q_lo, q_hi, q_data;
  logic                   qv_lo, qv_hi, qv_data;
  logic [VW-1:0]          wr_idx, rd_idx;
  logic                   wr_lo, wr_hi, wr_dat, wr_msk;

  assign wr_idx = wr.vec[VW-1:0];
  assign rd_idx = rd_vec[VW-1:0];
  assign wr_lo  = wr.en && (wr.field == FLD_ADDR_LO);
  assign wr_hi  = wr.en && (wr.field == FLD_ADDR_HI);
  assign wr_dat = wr.en && (wr.field == FLD_DATA);
  assign wr_msk = wr.en && (wr.field == FLD_MASK);

  always_ff @(posedge clk) begin
    if (wr_lo) begin
      mem_lo[wr_idx] <= wr.wdata;
    end
    if (wr_hi) begin
      mem_hi[wr_idx] <= wr.wdata;
    end
    if (wr_dat) begin
      mem_data[wr_idx] <= wr.wdata;
    end
    if (rd_en) begin
      q_lo   <= mem_lo[rd_idx];
      q_hi   <= mem_hi[rd_idx];
      q_data <= mem_data[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_lo   <= '0;
      vld_hi   <= '0;
      vld_data <= '0;
      lo_nz    <= '0;
      hi_nz    <= '0;
      mask     <= '1;
      qv_lo    <= 1'b0;
      qv_hi    <= 1'b0;
      qv_data  <= 1'b0;
    end else begin
      if (wr_lo) begin
        vld_lo[wr_idx] <= 1'b1;
        lo_nz[wr_idx]  <= (wr.wdata != '0);
      end
      if (wr_hi) begin
        vld_hi[wr_idx] <= 1'b1;
        hi_nz[wr_idx]  <= (wr.wdata != '0);
      end
      if (wr_dat) begin
        vld_data[wr_idx] <= 1'b1;
      end
      if (wr_msk) begin
        mask[wr_idx] <= wr.wdata[0];
      end
      if (rd_en) begin
        qv_lo   <= vld_lo[rd_idx];
        qv_hi   <= vld_hi[rd_idx];
        qv_data <= vld_data[rd_idx];
      end
    end
  end

  // entries never written read as zero
  assign rd_addr_lo = qv_lo ? q_lo : '0;
  assign rd_addr_hi = qv_hi ? q_hi : '0;
  assign rd_data    = qv_data ? q_data : '0;
  assign nonzero    = lo_nz | hi_nz;

endmodule

// ===== sv/mrpt_index_unit.sv =====
`timescale 1ns / 1ps
// shared decode unit: turns a request into an action and one table index, taken
// from the register offset, the write data or a priority encode of allowed vectors
// depends on mrpt_pkg

module mrpt_index_unit import mrpt_pkg::*; #(
  parameter int MAX_VECTORS        = DEF_MAX_VECTORS,
  parameter int TABLE_BASE         = DEF_TABLE_BASE,
  parameter int OUTSTANDING_OFFSET = DEF_OUTSTANDING_OFFSET,
  parameter int PENDING_OFFSET     = DEF_PENDING_OFFSET
) (
  input  logic [OP_W-1:0]        op,
  input  logic [ADDR_W-1:0]      address,
  input  logic [DATA_W-1:0]      write_data,
  input  logic [CNT_W-1:0]       active,
  input  logic                   msix_enable,
  input  logic                   function_mask,
  input  logic [MAX_VECTORS-1:0] pending,
  input  logic [MAX_VECTORS-1:0] mask,
  input  logic [MAX_VECTORS-1:0] nonzero,
  output look_t                  look
);

  localparam logic [ADDR_W-1:0] TB_OFF   = ADDR_W'(TABLE_BASE);
  localparam logic [ADDR_W-1:0] OUT_OFF  = ADDR_W'(OUTSTANDING_OFFSET);
  localparam logic [ADDR_W-1:0] PEND_OFF = ADDR_W'(PENDING_OFFSET);
  localparam int                TIDX_W   = ADDR_W - ENTRY_SHIFT;

  logic [MAX_VECTORS-1:0] act_mask, allowed;
  logic [VEC_W-1:0]       enc;
  logic [ADDR_W-1:0]      rel;
  logic [TIDX_W-1:0]      tidx;
  logic                   msg_ok;
  logic                   is_wr;

  always_comb begin
    for (int i = 0; i < MAX_VECTORS; i++) begin
      act_mask[i] = (CNT_W'(i) < active);
    end
  end

  assign allowed = pending & ~mask & nonzero & act_mask
                 & {MAX_VECTORS{msix_enable & ~function_mask}};

  always_comb begin
    enc = '0;
    for (int i = MAX_VECTORS - 1; i >= 0; i--) begin
      if (allowed[i]) begin
        enc = VEC_W'(i);
      end
    end
  end

  assign rel    = address - TB_OFF;
  assign tidx   = rel[ADDR_W-1:ENTRY_SHIFT];
  assign msg_ok = (write_data[MSG_W-1:0] < MSG_W'(active));
  assign is_wr  = (op == OP_CSR_WR);

  always_comb begin
    look        = '0;
    look.act    = ACT_NONE;
    look.status = 1'b0;
    look.vec    = write_data[VEC_W-1:0];
    look.field  = rel[3:2];
    case (op)
      OP_CSR_RD, OP_CSR_WR: begin
        if (address == '0) begin
          if (is_wr && msg_ok) begin
            look.act = ACT_RECV;
          end
        end else if (address == OUT_OFF) begin
          look.act = ACT_NONE;
        end else if (address == PEND_OFF) begin
          if (!is_wr) begin
            look.act = ACT_PBA_READ;
          end
        end else if (address < TB_OFF) begin
          look.status = 1'b1;
        end else if (tidx >= TIDX_W'(active)) begin
          look.status = 1'b1;
        end else if (rel[1:0] == 2'b00) begin
          look.act = is_wr ? ACT_TBL_WRITE : ACT_TBL_READ;
          look.vec = tidx[VEC_W-1:0];
        end
      end
      OP_MSI_WR: begin
        if (address != '0) begin
          look.status = 1'b1;
        end else if (msg_ok) begin
          look.act = ACT_RECV;
        end
      end
      OP_MSI_RD: begin
        look.act = ACT_NONE;
      end
      OP_TICK: begin
        look.vec = enc;
        look.act = (allowed != '0) ? ACT_EMIT : ACT_IDLE_TICK;
      end
      default: begin
        look.status = 1'b1;
      end
    endcase
  end

endmodule

// ===== sv/msix_relay_pending_table_top.sv =====
`timescale 1ns / 1ps
// msi-x relay top level: request sequencer, configuration, pending bits,
// response register; depends on mrpt_pkg, mrpt_if, mrpt_table, mrpt_index_unit
//
// usage
//   in_ch carries one request per transfer: csr read/write, msi port
//   write/read or a service tick. out_ch returns exactly one response per
//   request, in order. configuration is written on cfg_we/cfg_index/cfg_wdata
//   while no request is in flight.
//   each request goes through these steps in order: accept, decode and priority
//   encode in the shared index unit, one read or write of the vector table
//   memory, and the response register load. in_ch.ready is high only while the
//   sequencer is idle, so a new request is taken only after the last one is done.
//   the response register holds a result while out_ch is stalled; the next
//   request is still accepted and waits in its last step until the register
//   frees up.
//   reset clears the sequencer, the pending bits, the table valid bits and
//   sets all vector masks; the table reads as zero until written, so no
//   clearing pass is needed.

module msix_relay_pending_table_top import mrpt_pkg::*; #(
  parameter int MAX_VECTORS        = DEF_MAX_VECTORS,
  parameter int TABLE_BASE         = DEF_TABLE_BASE,
  parameter int OUTSTANDING_OFFSET = DEF_OUTSTANDING_OFFSET,
  parameter int PENDING_OFFSET     = DEF_PENDING_OFFSET
) (
  input  logic                  clk,
  input  logic                  rst,
  mrpt_in_if.sink               in_ch,
  mrpt_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int VW = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VECTORS);

  state_t state, state_next;

  logic             msix_enable, function_mask;
  logic [CNT_W-1:0] vector_count, active;

  logic [OP_W-1:0]   item_op;
  logic [ADDR_W-1:0] item_address;
  logic [DATA_W-1:0] item_wdata;
  logic              item_sink_ok;

  logic [MAX_VECTORS-1:0] pending, mask, nonzero;
  look_t                  look, look_q;
  logic [DATA_W-1:0]      pba_q;
  tbl_wr_t                tbl_wr;
  logic [DATA_W-1:0]      rd_addr_lo, rd_addr_hi, rd_data;

  logic in_ready, look_en, read_en, load_out;
  logic out_valid;

  logic [KIND_W-1:0]     res_kind;
  logic [DATA_W-1:0]     res_rdata;
  logic [MSI_ADDR_W-1:0] res_maddr;
  logic [DATA_W-1:0]     res_mdata;
  logic [VEC_W-1:0]      res_vec;

  assign active = (vector_count > MAX_CNT) ? MAX_CNT : vector_count;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      msix_enable   <= 1'b0;
      function_mask <= 1'b0;
      vector_count  <= COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE: msix_enable   <= cfg_wdata[0];
        CFG_FMASK:  function_mask <= cfg_wdata[0];
        CFG_COUNT:  vector_count  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_ch.valid) state_next = S_LOOK;
      S_LOOK: state_next = S_READ;
      S_READ: state_next = S_FIN;
      S_FIN:  if (!out_valid || out_ch.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == S_IDLE);
    look_en  = (state == S_LOOK);
    read_en  = (state == S_READ);
    load_out = (state == S_FIN) && (!out_valid || out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      item_op      <= in_ch.op;
      item_address <= in_ch.address;
      item_wdata   <= in_ch.write_data;
      item_sink_ok <= in_ch.sink_ok;
    end
    if (look_en) begin
      look_q <= look;
      pba_q  <= DATA_W'(pending);
    end
  end

  mrpt_index_unit #(
    .MAX_VECTORS        (MAX_VECTORS),
    .TABLE_BASE         (TABLE_BASE),
    .OUTSTANDING_OFFSET (OUTSTANDING_OFFSET),
    .PENDING_OFFSET     (PENDING_OFFSET)
  ) u_index (
    .op            (item_op),
    .address       (item_address),
    .write_data    (item_wdata),
    .active        (active),
    .msix_enable   (msix_enable),
    .function_mask (function_mask),
    .pending       (pending),
    .mask          (mask),
    .nonzero       (nonzero),
    .look          (look)
  );

  // pending bit array
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (look_en) begin
      if (look.act == ACT_RECV) begin
        pending[look.vec[VW-1:0]] <= 1'b1;
      end else if (look.act == ACT_EMIT && item_sink_ok) begin
        pending[look.vec[VW-1:0]] <= 1'b0;
      end
    end
  end

  always_comb begin
    tbl_wr.en    = read_en && (look_q.act == ACT_TBL_WRITE);
    tbl_wr.field = look_q.field;
    tbl_wr.vec   = look_q.vec;
    tbl_wr.wdata = item_wdata;
  end

  mrpt_table #(
    .MAX_VECTORS (MAX_VECTORS)
  ) u_table (
    .clk        (clk),
    .rst        (rst),
    .wr         (tbl_wr),
    .rd_en      (read_en),
    .rd_vec     (look_q.vec),
    .rd_addr_lo (rd_addr_lo),
    .rd_addr_hi (rd_addr_hi),
    .rd_data    (rd_data),
    .mask       (mask),
    .nonzero    (nonzero)
  );

  // response assembly
  always_comb begin
    res_kind  = KIND_ACCESS;
    res_rdata = '0;
    res_maddr = '0;
    res_mdata = '0;
    res_vec   = '0;
    case (look_q.act)
      ACT_PBA_READ: res_rdata = pba_q;
      ACT_TBL_READ: begin
        case (look_q.field)
          FLD_ADDR_LO: res_rdata = rd_addr_lo;
          FLD_ADDR_HI: res_rdata = rd_addr_hi;
          FLD_DATA:    res_rdata = rd_data;
          default:     res_rdata = DATA_W'(mask[look_q.vec[VW-1:0]]);
        endcase
      end
      ACT_EMIT: begin
        res_kind  = KIND_EMIT;
        res_maddr = {rd_addr_hi, rd_addr_lo};
        res_mdata = rd_data;
        res_vec   = look_q.vec;
      end
      ACT_IDLE_TICK: res_kind = KIND_NONE;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ch.resp_kind   <= res_kind;
      out_ch.status      <= look_q.status;
      out_ch.read_data   <= res_rdata;
      out_ch.msi_address <= res_maddr;
      out_ch.msi_data    <= res_mdata;
      out_ch.msi_vector  <= res_vec;
    end
  end

  assign out_ch.valid = out_valid;

  a_accept_to_look: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> state == S_LOOK)
    else $error("accepted request did not start decode");

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_READ && look_q.act == ACT_EMIT |-> {1'b0, look_q.vec} < active)
    else $error("emitted vector outside active range");

  a_emit_addr_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.resp_kind == KIND_EMIT |-> out_ch.msi_address != '0)
    else $error("emitted message with zero address");

  a_tick_status_ok: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.resp_kind != KIND_ACCESS |-> !out_ch.status)
    else $error("tick response carries an error status");

  a_hold_when_full: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN && out_valid && !out_ch.ready |=> state == S_FIN)
    else $error("response dropped while output stalled");

endmodule
